// ----- rtl/lcabl_pkg.sv -----
// Package for the binary-lifting lowest-common-ancestor block: widths, commands, states.
package lcabl_pkg;

   localparam int NODE_W      = 10;
   localparam int DEPTH_W     = 10;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic CMD_ATTACH = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_ROOT,
      ST_A_DEPTH,
      ST_A_READ,
      ST_A_WRITE,
      ST_Q_DEPTH,
      ST_Q_LIFT,
      ST_Q_LIFTW,
      ST_Q_CMP,
      ST_Q_CLIMB,
      ST_Q_CLIMBW,
      ST_Q_FINAL,
      ST_Q_FINALW,
      ST_Q_EMIT
   } state_type;

endpackage

// ----- rtl/lca_binary_lifting.sv -----
// Lowest common ancestor by binary lifting over an ancestor memory and a depth memory.
//
// Request channel (req_*): one item per command. req_tuser is the command (0 attach
// first_node under second_node, 1 query); req_tdata carries first_node and second_node.
// A node attached under itself is a root. Parents must be attached before children.
// Response channel (rsp_*): one item per query, carrying the lowest common ancestor.
// An attach gives no response.
// Items are handled one at a time; req_tready is high only while the sequencer is idle.
// Every table access goes through a memory with a registered read, so the cost of an
// item follows the lift levels L (LIFT_LEVELS):
//   attach of a root writes all L levels; other attach writes level 0, then reads and writes each level above.
//   query: lifts the deeper node by each set bit of the depth difference; when the lifted
//   node meets the other, that node is the answer, otherwise both nodes climb jointly
//   over every level, from the top down; a node out of range answers 0.
// A finished response waits in an output register; a stalled receiver holds the
// sequencer in its emit state only when a second response is ready behind it.
// Reset is synchronous and clears the sequencer and the response valid; the memory
// contents are not cleared and are undefined until written by attach items.
module lca_binary_lifting #(
   parameter int NODES       = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lcabl_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [9:0] first_node, [19:10] second_node
   input  logic                                req_tuser,   // [0] command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lcabl_pkg::RSP_TDATA_W-1:0]   rsp_tdata    // [9:0] common_ancestor
);

   localparam int NW        = lcabl_pkg::NODE_W;
   localparam int DW        = lcabl_pkg::DEPTH_W;
   localparam int IDX_W     = $clog2(NODES);
   localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int ANC_DEPTH = NODES * (2 ** LVL_W);
   localparam int AA_W      = IDX_W + LVL_W;

   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LIFT_LEVELS - 1);
   localparam logic [LVL_W-1:0] LVL_ZERO = '0;
   localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

   logic [NW-1:0] anc_mem [ANC_DEPTH];
   logic [DW-1:0] dep_mem [NODES];

   lcabl_pkg::state_type state_ff, state_in;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic [NW-1:0]          u_ff, u_in;
   logic [NW-1:0]          v_ff, v_in;
   logic [LIFT_LEVELS-1:0] diff_ff, diff_in;
   logic [NW-1:0]          res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]          rsp_data_ff, rsp_data_in;

   logic [NW-1:0]    anc_rda_ff, anc_rdb_ff;
   logic [DW-1:0]    dep_rda_ff, dep_rdb_ff;
   logic [AA_W-1:0]  anc_ra_a, anc_ra_b, anc_wa;
   logic [IDX_W-1:0] dep_ra_a, dep_ra_b, dep_wa;
   logic             anc_we, dep_we;
   logic [NW-1:0]    anc_wd;
   logic [DW-1:0]    dep_wd;

   logic [NW-1:0]    req_first, req_second;
   logic [IDX_W-1:0] req_first_idx, req_second_idx, u_idx, v_idx;
   logic             req_in_range;
   logic [DW-1:0]    diff_ab, diff_ba;

   assign req_first      = req_tdata[NW-1:0];
   assign req_second     = req_tdata[2*NW-1:NW];
   assign req_first_idx  = IDX_W'(req_first);
   assign req_second_idx = IDX_W'(req_second);
   assign u_idx          = IDX_W'(u_ff);
   assign v_idx          = IDX_W'(v_ff);
   assign req_in_range   = ({22'd0, req_first} < 32'(NODES)) &&
                           ({22'd0, req_second} < 32'(NODES));
   assign diff_ab        = dep_rda_ff - dep_rdb_ff;
   assign diff_ba        = dep_rdb_ff - dep_rda_ff;

   assign req_tready = (state_ff == lcabl_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lcabl_pkg::RSP_TDATA_W'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_wa] <= anc_wd;
      end
      anc_rda_ff <= anc_mem[anc_ra_a];
      anc_rdb_ff <= anc_mem[anc_ra_b];
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_wa] <= dep_wd;
      end
      dep_rda_ff <= dep_mem[dep_ra_a];
      dep_rdb_ff <= dep_mem[dep_ra_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcabl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff      <= lvl_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      diff_ff     <= diff_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      diff_in      = diff_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      dep_we       = 1'b0;
      dep_wa       = req_first_idx;
      dep_wd       = '0;
      dep_ra_a     = req_first_idx;
      dep_ra_b     = req_second_idx;
      anc_we       = 1'b0;
      anc_wa       = {u_idx, lvl_ff};
      anc_wd       = v_ff;
      anc_ra_a     = {u_idx, lvl_ff};
      anc_ra_b     = {v_idx, lvl_ff};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         lcabl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               u_in   = req_first;
               v_in   = req_second;
               lvl_in = LVL_ZERO;
               if (req_tuser == lcabl_pkg::CMD_QUERY) begin
                  if (req_in_range) begin
                     state_in = lcabl_pkg::ST_Q_DEPTH;
                  end else begin
                     res_in   = '0;
                     state_in = lcabl_pkg::ST_Q_EMIT;
                  end
               end else if (req_in_range) begin
                  if (req_first == req_second) begin
                     dep_we   = 1'b1;
                     state_in = lcabl_pkg::ST_A_ROOT;
                  end else begin
                     dep_ra_a = req_second_idx;
                     state_in = lcabl_pkg::ST_A_DEPTH;
                  end
               end
            end
         end
         lcabl_pkg::ST_A_ROOT: begin
            anc_we = 1'b1;
            anc_wd = u_ff;
            if (lvl_ff == LVL_LAST) begin
               state_in = lcabl_pkg::ST_IDLE;
            end else begin
               lvl_in = lvl_ff + LVL_ONE;
            end
         end
         lcabl_pkg::ST_A_DEPTH: begin
            dep_we = 1'b1;
            dep_wa = u_idx;
            dep_wd = dep_rda_ff + DW'(1);
            anc_we = 1'b1;
            anc_wa = {u_idx, LVL_ZERO};
            if (LIFT_LEVELS == 1) begin
               state_in = lcabl_pkg::ST_IDLE;
            end else begin
               lvl_in   = LVL_ONE;
               state_in = lcabl_pkg::ST_A_READ;
            end
         end
         lcabl_pkg::ST_A_READ: begin
            // v holds the ancestor written one level below
            anc_ra_a = {v_idx, lvl_ff - LVL_ONE};
            state_in = lcabl_pkg::ST_A_WRITE;
         end
         lcabl_pkg::ST_A_WRITE: begin
            anc_we = 1'b1;
            anc_wd = anc_rda_ff;
            v_in   = anc_rda_ff;
            if (lvl_ff == LVL_LAST) begin
               state_in = lcabl_pkg::ST_IDLE;
            end else begin
               lvl_in   = lvl_ff + LVL_ONE;
               state_in = lcabl_pkg::ST_A_READ;
            end
         end
         lcabl_pkg::ST_Q_DEPTH: begin
            if (dep_rda_ff < dep_rdb_ff) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = LIFT_LEVELS'(diff_ba);
            end else begin
               diff_in = LIFT_LEVELS'(diff_ab);
            end
            lvl_in   = LVL_ZERO;
            state_in = lcabl_pkg::ST_Q_LIFT;
         end
         lcabl_pkg::ST_Q_LIFT: begin
            if (diff_ff[lvl_ff]) begin
               state_in = lcabl_pkg::ST_Q_LIFTW;
            end else if (lvl_ff == LVL_LAST) begin
               state_in = lcabl_pkg::ST_Q_CMP;
            end else begin
               lvl_in = lvl_ff + LVL_ONE;
            end
         end
         lcabl_pkg::ST_Q_LIFTW: begin
            u_in = anc_rda_ff;
            if (lvl_ff == LVL_LAST) begin
               state_in = lcabl_pkg::ST_Q_CMP;
            end else begin
               lvl_in   = lvl_ff + LVL_ONE;
               state_in = lcabl_pkg::ST_Q_LIFT;
            end
         end
         lcabl_pkg::ST_Q_CMP: begin
            if (u_ff == v_ff) begin
               res_in   = u_ff;
               state_in = lcabl_pkg::ST_Q_EMIT;
            end else begin
               lvl_in   = LVL_LAST;
               state_in = lcabl_pkg::ST_Q_CLIMB;
            end
         end
         lcabl_pkg::ST_Q_CLIMB: begin
            state_in = lcabl_pkg::ST_Q_CLIMBW;
         end
         lcabl_pkg::ST_Q_CLIMBW: begin
            if (anc_rda_ff != anc_rdb_ff) begin
               u_in = anc_rda_ff;
               v_in = anc_rdb_ff;
            end
            if (lvl_ff == LVL_ZERO) begin
               state_in = lcabl_pkg::ST_Q_FINAL;
            end else begin
               lvl_in   = lvl_ff - LVL_ONE;
               state_in = lcabl_pkg::ST_Q_CLIMB;
            end
         end
         lcabl_pkg::ST_Q_FINAL: begin
            anc_ra_a = {u_idx, LVL_ZERO};
            state_in = lcabl_pkg::ST_Q_FINALW;
         end
         lcabl_pkg::ST_Q_FINALW: begin
            res_in   = anc_rda_ff;
            state_in = lcabl_pkg::ST_Q_EMIT;
         end
         lcabl_pkg::ST_Q_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = lcabl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcabl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- verif/lca_checker.sv -----
// Checker for lca_binary_lifting: watches both channels, predicts each common ancestor, compares.
`timescale 1ns / 100ps

module lca_checker #(
   parameter int NODES       = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [lcabl_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [9:0] first_node, [19:10] second_node
   input  logic                                req_tuser,   // [0] command
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [lcabl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [9:0] common_ancestor
   output int                                  fail_count,
   output int                                  pending
);

   localparam int NODE_W  = lcabl_pkg::NODE_W;
   localparam int DEPTH_W = lcabl_pkg::DEPTH_W;

   logic [NODE_W-1:0]  lift_tab [NODES][LIFT_LEVELS];
   logic [DEPTH_W-1:0] depth_tab [NODES];
   logic [NODE_W-1:0]  ancestor_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [NODE_W-1:0] lift_of(input logic [NODE_W-1:0] node, input int level);
      if (int'(node) >= NODES || level >= LIFT_LEVELS) return '0;
      return lift_tab[node][level];
   endfunction

   function automatic logic [DEPTH_W-1:0] depth_of(input logic [NODE_W-1:0] node);
      if (int'(node) >= NODES) return '0;
      return depth_tab[node];
   endfunction

   task automatic hang_node(input logic [NODE_W-1:0] child, input logic [NODE_W-1:0] parent);
      if (int'(child) >= NODES || int'(parent) >= NODES) return;
      if (child == parent) begin
         depth_tab[child] = '0;
         for (int k = 0; k < LIFT_LEVELS; k++) lift_tab[child][k] = child;
         return;
      end
      depth_tab[child]   = depth_of(parent) + 1'b1;
      lift_tab[child][0] = parent;
      for (int k = 1; k < LIFT_LEVELS; k++)
         lift_tab[child][k] = lift_of(lift_of(child, k - 1), k - 1);
   endtask

   function automatic logic [NODE_W-1:0] lowest_common(input logic [NODE_W-1:0] a,
                                                       input logic [NODE_W-1:0] b);
      logic [NODE_W-1:0]  u, v, t, au, av;
      logic [DEPTH_W-1:0] diff;
      if (int'(a) >= NODES || int'(b) >= NODES) return '0;
      u = a;
      v = b;
      if (depth_of(u) < depth_of(v)) begin
         t = u;
         u = v;
         v = t;
      end
      diff = depth_of(u) - depth_of(v);
      for (int i = 0; i < LIFT_LEVELS && i < DEPTH_W; i++)
         if (diff[i]) u = lift_of(u, i);
      if (u == v) return u;
      for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
         au = lift_of(u, i);
         av = lift_of(v, i);
         if (au != av) begin
            u = au;
            v = av;
         end
      end
      return lift_of(u, 0);
   endfunction

   task automatic report_mismatch(input string what, input logic [NODE_W-1:0] got,
                                  input logic [NODE_W-1:0] want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [NODE_W-1:0] want;
      if (!reset) begin
         // a response never belongs to a query taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (ancestor_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[NODE_W-1:0], '0);
            end else begin
               want = ancestor_q.pop_front();
               if (rsp_tdata[NODE_W-1:0] !== want)
                  report_mismatch("common_ancestor", rsp_tdata[NODE_W-1:0], want);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == lcabl_pkg::CMD_ATTACH)
               hang_node(req_tdata[NODE_W-1:0], req_tdata[2*NODE_W-1:NODE_W]);
            else
               ancestor_q = {ancestor_q, lowest_common(req_tdata[NODE_W-1:0],
                                                       req_tdata[2*NODE_W-1:NODE_W])};
         end
      end
      pending = ancestor_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
// Testbench top for lca_binary_lifting: clock, reset, tree-building stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int NODE_W         = lcabl_pkg::NODE_W;
   localparam int REQ_TDATA_W    = lcabl_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W    = lcabl_pkg::RSP_TDATA_W;
   localparam int NODES          = 1024;
   localparam int LIFT_LEVELS    = 10;
   localparam int RANDOM_ITEMS   = 220;
   localparam int CHAIN_LEN      = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     fail_count;
   int                     pending;

   bit                     attached_map [NODES];
   int                     attached_list [$];
   logic [NODE_W-1:0]      last_child;
   bit                     send_burst;
   bit                     rsp_burst;
   int                     stall_left;
   int                     idle_cycles;

   lca_binary_lifting #(
      .NODES       (NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   lca_checker #(
      .NODES       (NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_burst && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[lca_binary_lifting] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_cmd(input logic cmd, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b);
      int gap;
      gap = send_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - 2*NODE_W){1'b0}}, b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic attach(input logic [NODE_W-1:0] child, input logic [NODE_W-1:0] parent);
      send_cmd(lcabl_pkg::CMD_ATTACH, child, parent);
      if (!attached_map[child]) begin
         attached_map[child] = 1'b1;
         attached_list = {attached_list, int'(child)};
      end
      last_child = child;
   endtask

   function automatic logic [NODE_W-1:0] any_attached();
      return NODE_W'(attached_list[$urandom_range(0, attached_list.size() - 1)]);
   endfunction

   initial begin
      logic [NODE_W-1:0] child, parent, a, b;
      int                r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = lcabl_pkg::CMD_ATTACH;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      stall_left = 0;
      idle_cycles = 0;
      send_burst = 1'b0;
      rsp_burst  = 1'b0;
      last_child = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: roots, deep and sibling branches, re-attach, separate trees
      attach(10'd5, 10'd5);
      attach(10'd1023, 10'd5);
      attach(10'd0, 10'd1023);
      attach(10'd512, 10'd0);
      attach(10'd341, 10'd512);
      attach(10'd682, 10'd1023);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd0, 10'd0);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd341, 10'd682);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd682, 10'd341);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd5, 10'd341);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd1023, 10'd1023);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd341, 10'd0);
      attach(10'd0, 10'd0);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd0, 10'd5);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd341, 10'd512);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd1023, 10'd0);
      attach(10'd1023, 10'd341);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd682, 10'd341);
      send_cmd(lcabl_pkg::CMD_QUERY, 10'd1023, 10'd5);

      // random: grow trees (often deepening the last chain) and query attached pairs
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
            rsp_burst  = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         if (r < 45) begin
            child = NODE_W'($urandom_range(0, NODES - 1));
            r = $urandom_range(0, 99);
            if (r < 50)      parent = last_child;
            else if (r < 90) parent = any_attached();
            else             parent = child;
            attach(child, parent);
         end else begin
            a = any_attached();
            b = ($urandom_range(0, 99) < 15) ? a : any_attached();
            send_cmd(lcabl_pkg::CMD_QUERY, a, b);
         end
      end

      // one long chain for large depth differences, then hang its root under its tail
      send_burst = 1'b1;
      rsp_burst  = 1'b0;
      attach(10'd0, 10'd0);
      for (int i = 1; i < CHAIN_LEN; i++) attach(NODE_W'(i), NODE_W'(i - 1));
      send_burst = 1'b0;
      for (int n = 0; n < 40; n++)
         send_cmd(lcabl_pkg::CMD_QUERY, NODE_W'($urandom_range(0, CHAIN_LEN - 1)),
                  NODE_W'($urandom_range(0, CHAIN_LEN - 1)));
      attach(10'd0, NODE_W'(CHAIN_LEN - 1));
      attach(10'd5, 10'd0);
      rsp_burst = 1'b1;
      for (int n = 0; n < 30; n++) begin
         a = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd5;
         b = NODE_W'($urandom_range(0, CHAIN_LEN - 1));
         if ($urandom_range(0, 1) == 0) send_cmd(lcabl_pkg::CMD_QUERY, a, b);
         else                          send_cmd(lcabl_pkg::CMD_QUERY, b, a);
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[lca_binary_lifting] OK");
      end else begin
         $display("[lca_binary_lifting] ERROR");
      end
      $finish;
   end

endmodule
